// ===== hw/rtl/buffer_swizzle_address_top_macros.svh =====
// Assertion macros shared by the buffer swizzle address RTL.
`ifndef BUFFER_SWIZZLE_ADDRESS_TOP_MACROS_SVH
`define BUFFER_SWIZZLE_ADDRESS_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in the next cycle follows from a condition now.
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bsa_pkg.sv =====
// Shared types and constants for the buffer swizzle address block.
package bsa_pkg;

  localparam int NumStages = 4;
  localparam int FieldW    = 32;
  localparam int LaneW     = 6;
  localparam int StrideW   = 14;
  localparam int EslW      = 2;
  localparam int CountW    = 32;
  localparam int DataW     = 32;
  localparam int PaddrW    = 5;
  localparam int RegIdxW   = 3;
  localparam int LoW       = 6;
  localparam int SmallW    = 8;

  typedef enum logic [RegIdxW-1:0] {
    REG_RECORD_STRIDE      = 3'd0,
    REG_ADD_LANE_ENABLE    = 3'd1,
    REG_SWIZZLE_ENABLE     = 3'd2,
    REG_ELEMENT_STRIDE_LOG = 3'd3,
    REG_RECORD_COUNT       = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [StrideW-1:0] record_stride;
    logic               add_lane_enable;
    logic               swizzle_enable;
    logic [EslW-1:0]    element_stride_log;
    logic [CountW-1:0]  record_count;
  } cfg_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/bsa_cfg_regs.sv =====
// APB register file holding the buffer descriptor fields.
module bsa_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bsa_pkg::PaddrW-1:0] paddr,
  input  logic [bsa_pkg::DataW-1:0]  pwdata,
  output logic [bsa_pkg::DataW-1:0]  prdata,
  output logic                      pready,
  output bsa_pkg::cfg_t             cfg
);
  import bsa_pkg::*;

  reg_index_t sel;
  logic       wr_en;

  assign sel    = reg_index_t'(paddr[PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (sel)
        REG_RECORD_STRIDE:      cfg.record_stride      <= pwdata[StrideW-1:0];
        REG_ADD_LANE_ENABLE:    cfg.add_lane_enable    <= pwdata[0];
        REG_SWIZZLE_ENABLE:     cfg.swizzle_enable     <= pwdata[0];
        REG_ELEMENT_STRIDE_LOG: cfg.element_stride_log <= pwdata[EslW-1:0];
        REG_RECORD_COUNT:       cfg.record_count       <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_RECORD_STRIDE:      prdata = DataW'(cfg.record_stride);
      REG_ADD_LANE_ENABLE:    prdata = DataW'(cfg.add_lane_enable);
      REG_SWIZZLE_ENABLE:     prdata = DataW'(cfg.swizzle_enable);
      REG_ELEMENT_STRIDE_LOG: prdata = DataW'(cfg.element_stride_log);
      REG_RECORD_COUNT:       prdata = DataW'(cfg.record_count);
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/bsa_pipe_ctrl.sv =====
// Valid bits and stall control for the address pipeline.
module bsa_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 result_ready,
  output logic                 item_ready,
  output logic                 result_valid,
  output bsa_pkg::pipe_ctl_t   ctl
);
  import bsa_pkg::*;

  logic [NumStages-1:0] valid;
  logic [NumStages-1:0] valid_next;
  logic [NumStages-1:0] rdy;

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    rdy[NumStages-1] = !valid[NumStages-1] || result_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
    ctl.load[0]   = item_valid && rdy[0];
    valid_next[0] = rdy[0] ? item_valid : valid[0];
    for (int k = 1; k < NumStages; k++) begin
      ctl.load[k]   = valid[k-1] && rdy[k];
      valid_next[k] = rdy[k] ? valid[k-1] : valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign item_ready   = rdy[0];
  assign result_valid = valid[NumStages-1];

endmodule

// ===== hw/rtl/bsa_datapath.sv =====
// Four-stage address datapath: lane add, multiply, offset add, swizzle merge.
module bsa_datapath #(
  parameter int ADDR_WIDTH = 32,
  parameter int LANE_BITS  = 6
) (
  input  logic                        clk,
  input  bsa_pkg::cfg_t               cfg,
  input  bsa_pkg::pipe_ctl_t          ctl,
  input  logic [bsa_pkg::FieldW-1:0]  record_index,
  input  logic [bsa_pkg::FieldW-1:0]  byte_offset,
  input  logic [bsa_pkg::FieldW-1:0]  scalar_byte_offset,
  input  logic [bsa_pkg::LaneW-1:0]   lane_number,
  output logic [bsa_pkg::FieldW-1:0]  access_address,
  output logic                        raw_descriptor_ok,
  output logic                        always_out_of_range
);
  import bsa_pkg::*;

  localparam int AW = ADDR_WIDTH;

  logic                   swz;
  logic [2:0]             sh;
  logic [LoW-1:0]         lo_mask;

  logic [AW-1:0]          idx_in;
  logic [AW-1:0]          lane_ext;
  logic [AW-1:0]          mul_a;
  logic [AW+StrideW-1:0]  prod_full;
  logic [AW-1:0]          off_part;
  logic [SmallW-1:0]      small_part;
  logic [AW-1:0]          base;

  logic [AW-1:0]          s1_idx, s1_off, s1_soff;
  logic [AW-1:0]          s2_prod, s2_off, s2_soff;
  logic [LoW-1:0]         s2_lo;
  logic [AW-1:0]          s3_t, s3_soff;
  logic [SmallW-1:0]      s3_small;
  logic [AW-1:0]          s4_addr;

  assign swz     = cfg.swizzle_enable && (cfg.record_stride != '0);
  assign sh      = 3'(cfg.element_stride_log) + 3'd3;
  assign lo_mask = LoW'((7'd8 << cfg.element_stride_log) - 7'd1);

  // Stage 1: fold the lane into the record index.
  assign idx_in   = AW'(record_index);
  assign lane_ext = AW'(lane_number[LANE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_idx  <= cfg.add_lane_enable ? idx_in + lane_ext : idx_in;
      s1_off  <= AW'(byte_offset);
      s1_soff <= AW'(scalar_byte_offset);
    end
  end

  // Stage 2: scale the (element-split) index by the record stride.
  assign mul_a     = swz ? (s1_idx >> sh) : s1_idx;
  assign prod_full = mul_a * cfg.record_stride;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_prod <= prod_full[AW-1:0];
      s2_lo   <= s1_idx[LoW-1:0] & lo_mask;
      s2_off  <= s1_off;
      s2_soff <= s1_soff;
    end
  end

  // Stage 3: add the offset; swizzle keeps only its dword part here.
  assign off_part   = swz ? {s2_off[AW-1:2], 2'b00} : s2_off;
  assign small_part = swz ? ({s2_lo, 2'b00} + SmallW'(s2_off[1:0])) : '0;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_t     <= s2_prod + off_part;
      s3_small <= small_part;
      s3_soff  <= s2_soff;
    end
  end

  // Stage 4: scale by the element stride and add the low parts and scalar offset.
  assign base = swz ? (s3_t << sh) : s3_t;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s4_addr <= base + s3_soff + AW'(s3_small);
    end
  end

  assign access_address      = FieldW'(s4_addr);
  assign raw_descriptor_ok   = (cfg.record_stride != '0) && (cfg.record_stride[1:0] == 2'b00);
  assign always_out_of_range = (cfg.record_count == '0);

endmodule

// ===== hw/rtl/buffer_swizzle_address_top.sv =====
// A word is loaded into the first of four register stages when it is accepted, and
// result_valid rises when it reaches the last stage.
// Throughput: one word per cycle; the pipeline stalls only when the result side holds off.
// The lane add, the index-by-stride multiply, the offset add and the swizzle merge each own a stage.
// Reset (synchronous, active high) empties the pipeline and clears all descriptor registers to 0.
// Descriptor registers are expected to change only while no word is in flight.
`include "buffer_swizzle_address_top_macros.svh"

module buffer_swizzle_address_top #(
  parameter int ADDR_WIDTH = 32,
  parameter int LANE_BITS  = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB descriptor port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsa_pkg::PaddrW-1:0]  paddr,
  input  logic [bsa_pkg::DataW-1:0]   pwdata,
  output logic [bsa_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  // access words in
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [bsa_pkg::FieldW-1:0]  record_index,
  input  logic [bsa_pkg::FieldW-1:0]  byte_offset,
  input  logic [bsa_pkg::FieldW-1:0]  scalar_byte_offset,
  input  logic [bsa_pkg::LaneW-1:0]   lane_number,
  // address words out
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [bsa_pkg::FieldW-1:0]  access_address,
  output logic                        raw_descriptor_ok,
  output logic                        always_out_of_range
);
  import bsa_pkg::*;

  cfg_t      cfg;
  pipe_ctl_t ctl;

  // Descriptor registers; reads return the stored field zero-extended.
  bsa_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Valid bits travel beside the data; each stage advances when the next one frees up.
  bsa_pipe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .result_ready (result_ready),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .ctl          (ctl)
  );

  // Address arithmetic wraps at ADDR_WIDTH bits; the result port carries the low 32.
  bsa_datapath #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .LANE_BITS  (LANE_BITS)
  ) u_dp (
    .clk                 (clk),
    .cfg                 (cfg),
    .ctl                 (ctl),
    .record_index        (record_index),
    .byte_offset         (byte_offset),
    .scalar_byte_offset  (scalar_byte_offset),
    .lane_number         (lane_number),
    .access_address      (access_address),
    .raw_descriptor_ok   (raw_descriptor_ok),
    .always_out_of_range (always_out_of_range)
  );

  // Backpressure at the input only comes from a full pipeline with a waiting result.
  `BSA_ASSERT(a_full_implies_result, !item_ready |-> result_valid, "input stalled with no result")
  // A taken result frees every stage, so the input must be ready.
  `BSA_ASSERT(a_ready_chain, result_ready |-> item_ready, "ready chain broken")
  // Hold a refused result and its address until the receiver takes it.
  `BSA_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(access_address), "result dropped or changed while stalled")
  // Reset leaves the pipeline empty.
  `BSA_ASSERT(a_reset_empty, $past(rst) |-> !result_valid, "result valid right after reset")

endmodule

// ===== tb/sv/tb_buffer_swizzle_address_top.sv =====
// Self-checking testbench for the buffer swizzle address block.
module tb_buffer_swizzle_address_top;
  import bsa_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 3;
  // Four register stages; leave some margin before touching the descriptor.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_WORDS   = 130;
  localparam int HOLD_CYCLES   = 300;
  // Far above the worst-case run time of the test.
  localparam int TIMEOUT       = 20000000;

  // Register indexes past the descriptor; writes there must be dropped.
  localparam logic [RegIdxW-1:0] FIRST_SPARE_REG = 3'd5;
  localparam logic [RegIdxW-1:0] LAST_SPARE_REG  = 3'd7;
  localparam logic [StrideW-1:0] STRIDE_MAX      = '1;
  localparam logic [CountW-1:0]  COUNT_MAX       = '1;

  // One address word as the block returns it.
  typedef struct packed {
    logic [FieldW-1:0] access_address;
    logic              raw_descriptor_ok;
    logic              always_out_of_range;
  } addr_word_t;

  // One row of the directed table: descriptor, access and optional known answer.
  typedef struct {
    cfg_t              cfg;
    logic [FieldW-1:0] idx;
    logic [FieldW-1:0] off;
    logic [FieldW-1:0] soff;
    logic [LaneW-1:0]  lane;
    bit                typed;
    addr_word_t        want;
  } access_row_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                item_valid;
  logic                item_ready;
  logic [FieldW-1:0]   record_index;
  logic [FieldW-1:0]   byte_offset;
  logic [FieldW-1:0]   scalar_byte_offset;
  logic [LaneW-1:0]    lane_number;
  logic                result_valid;
  logic                result_ready;
  logic [FieldW-1:0]   access_address;
  logic                raw_descriptor_ok;
  logic                always_out_of_range;

  // Descriptor as the block should hold it, and the answer for the word on offer.
  cfg_t                shadow_cfg;
  addr_word_t          offered_word;
  addr_word_t          address_q[$];
  access_row_t         directed_rows[$];
  int unsigned         fails;
  bit                  hold_request;

  buffer_swizzle_address_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .item_valid          (item_valid),
    .item_ready          (item_ready),
    .record_index        (record_index),
    .byte_offset         (byte_offset),
    .scalar_byte_offset  (scalar_byte_offset),
    .lane_number         (lane_number),
    .result_valid        (result_valid),
    .result_ready        (result_ready),
    .access_address      (access_address),
    .raw_descriptor_ok   (raw_descriptor_ok),
    .always_out_of_range (always_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case a word never comes back.
  initial begin
    #TIMEOUT;
    $display("RESULT: ERROR");
    $finish;
  end

  // Compute the address word for one access under a given descriptor.
  // All arithmetic is 32 bits wide, so every sum and product wraps by itself.
  function automatic addr_word_t predict_address(cfg_t c, logic [FieldW-1:0] idx_in,
                                                 logic [FieldW-1:0] off,
                                                 logic [FieldW-1:0] soff,
                                                 logic [LaneW-1:0] lane);
    logic [FieldW-1:0] idx;
    logic [FieldW-1:0] stride;
    logic [FieldW-1:0] elem;
    logic [FieldW-1:0] hi;
    logic [FieldW-1:0] lo;
    logic [FieldW-1:0] t;
    logic [FieldW-1:0] addr;
    logic [FieldW-1:0] shift;
    addr_word_t        w;
    idx    = idx_in;
    stride = FieldW'(c.record_stride);
    if (c.add_lane_enable) begin
      idx = idx + FieldW'(lane);
    end
    if (c.swizzle_enable && stride != 0) begin
      // Split the index by the element stride and the offset at dword grain.
      shift = FieldW'(c.element_stride_log);
      shift = shift + 3;
      elem  = 32'd8 << c.element_stride_log;
      hi    = idx >> shift;
      lo    = idx & (elem - 1);
      t     = hi * stride + (off & ~32'd3);
      addr  = t * elem + (lo << 2) + (off & 32'd3);
    end else begin
      addr = idx * stride + off;
    end
    w.access_address      = addr + soff;
    w.raw_descriptor_ok   = (stride != 0) && (stride[1:0] == 2'b00);
    w.always_out_of_range = (c.record_count == 0);
    return w;
  endfunction

  function automatic cfg_t mk_cfg(logic [StrideW-1:0] stride, logic lane_en, logic swz,
                                  logic [EslW-1:0] esl, logic [CountW-1:0] count);
    cfg_t c;
    c.record_stride      = stride;
    c.add_lane_enable    = lane_en;
    c.swizzle_enable     = swz;
    c.element_stride_log = esl;
    c.record_count       = count;
    return c;
  endfunction

  function automatic access_row_t mk_row(cfg_t c, logic [FieldW-1:0] idx,
                                         logic [FieldW-1:0] off, logic [FieldW-1:0] soff,
                                         logic [LaneW-1:0] lane, bit typed,
                                         logic [FieldW-1:0] addr, logic ok, logic oor);
    access_row_t r;
    r.cfg                      = c;
    r.idx                      = idx;
    r.off                      = off;
    r.soff                     = soff;
    r.lane                     = lane;
    r.typed                    = typed;
    r.want.access_address      = addr;
    r.want.raw_descriptor_ok   = ok;
    r.want.always_out_of_range = oor;
    return r;
  endfunction

  // Bias the stride toward zero and dword multiples so both flag values show up.
  function automatic cfg_t random_cfg();
    logic [StrideW-1:0] stride;
    logic [CountW-1:0]  count;
    case ($urandom_range(0, 7))
      0:       stride = '0;
      1, 2:    stride = StrideW'($urandom() & ~32'd3);
      default: stride = StrideW'($urandom());
    endcase
    count = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
    return mk_cfg(stride, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                  EslW'($urandom_range(0, 3)), count);
  endfunction

  // Mix small values and values near the top so the wrap is hit often.
  function automatic logic [FieldW-1:0] pick_field();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 255);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int pick_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [DataW-1:0] reg_readback(logic [RegIdxW-1:0] ridx);
    logic [DataW-1:0] v;
    v = '0;
    case (ridx)
      REG_RECORD_STRIDE:      v = DataW'(shadow_cfg.record_stride);
      REG_ADD_LANE_ENABLE:    v = DataW'(shadow_cfg.add_lane_enable);
      REG_SWIZZLE_ENABLE:     v = DataW'(shadow_cfg.swizzle_enable);
      REG_ELEMENT_STRIDE_LOG: v = DataW'(shadow_cfg.element_stride_log);
      REG_RECORD_COUNT:       v = DataW'(shadow_cfg.record_count);
      default:                v = '0;
    endcase
    return v;
  endfunction

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input bit wr, input logic [RegIdxW-1:0] ridx,
                            input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {ridx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, track it, and read it back where it exists.
  task automatic write_reg(input logic [RegIdxW-1:0] ridx, input logic [DataW-1:0] data);
    logic [DataW-1:0] rd;
    apb_access(1'b1, ridx, data, rd);
    case (ridx)
      REG_RECORD_STRIDE:      shadow_cfg.record_stride      = data[StrideW-1:0];
      REG_ADD_LANE_ENABLE:    shadow_cfg.add_lane_enable    = data[0];
      REG_SWIZZLE_ENABLE:     shadow_cfg.swizzle_enable     = data[0];
      REG_ELEMENT_STRIDE_LOG: shadow_cfg.element_stride_log = data[EslW-1:0];
      REG_RECORD_COUNT:       shadow_cfg.record_count       = data[CountW-1:0];
      default: ;
    endcase
    if (ridx < FIRST_SPARE_REG) begin
      apb_access(1'b0, ridx, '0, rd);
      if (rd !== reg_readback(ridx)) begin
        $error("prdata of register %0d: expected %h actual %h", ridx, reg_readback(ridx), rd);
        fails++;
      end
    end
  endtask

  // Load a whole descriptor; junk above each narrower field must be dropped,
  // and a spare index gets a stray write that must change nothing.
  task automatic load_descriptor(input cfg_t c);
    write_reg(REG_RECORD_STRIDE, ($urandom() << StrideW) | c.record_stride);
    write_reg(REG_ADD_LANE_ENABLE, ($urandom() << 1) | c.add_lane_enable);
    write_reg(REG_SWIZZLE_ENABLE, ($urandom() << 1) | c.swizzle_enable);
    write_reg(REG_ELEMENT_STRIDE_LOG, ($urandom() << EslW) | c.element_stride_log);
    write_reg(REG_RECORD_COUNT, c.record_count);
    write_reg(RegIdxW'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)), $urandom());
  endtask

  // Drop valid and wait for every outstanding address word to come back.
  task automatic drain_words();
    @(negedge clk);
    item_valid <= 1'b0;
    while (address_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Offer one access word after an optional gap and hold it until accepted.
  task automatic send_word(input logic [FieldW-1:0] idx, input logic [FieldW-1:0] off,
                           input logic [FieldW-1:0] soff, input logic [LaneW-1:0] lane,
                           input int gap, input bit typed, input addr_word_t want);
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid         <= 1'b1;
    record_index       <= idx;
    byte_offset        <= off;
    scalar_byte_offset <= soff;
    lane_number        <= lane;
    offered_word       <= typed ? want : predict_address(shadow_cfg, idx, off, soff, lane);
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // Scoreboard: queue the answer of each accepted access, check each returned word.
  always @(posedge clk) begin : address_check
    addr_word_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        address_q.push_back(offered_word);
      end
      if (result_valid && result_ready) begin
        if (address_q.size() == 0) begin
          $error("address word with nothing outstanding: access_address %h", access_address);
          fails++;
        end else begin
          want = address_q.pop_front();
          if (access_address !== want.access_address) begin
            $error("access_address: expected %h actual %h", want.access_address,
                   access_address);
            fails++;
          end
          if (raw_descriptor_ok !== want.raw_descriptor_ok) begin
            $error("raw_descriptor_ok: expected %b actual %b",
                   want.raw_descriptor_ok, raw_descriptor_ok);
            fails++;
          end
          if (always_out_of_range !== want.always_out_of_range) begin
            $error("always_out_of_range: expected %b actual %b",
                   want.always_out_of_range, always_out_of_range);
            fails++;
          end
        end
      end
    end
  end

  // Result side: random stalls of mixed length, plus one long hold-off on request
  // so the pipeline fills and pushes back on the sender.
  initial begin : result_side
    int pick;
    int len;
    result_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        len = HOLD_CYCLES;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          result_ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (pick < 60) begin
          result_ready <= 1'b1;
          len = 100;
        end else if (pick < 95) begin
          result_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          result_ready <= 1'b0;
          len = $urandom_range(10, 40);
        end
      end
      repeat (len) @(negedge clk);
    end
  end

  initial begin : stimulus
    cfg_t        c;
    access_row_t row;
    addr_word_t  none;
    bit          no_idle;

    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    item_valid         = 1'b0;
    record_index       = '0;
    byte_offset        = '0;
    scalar_byte_offset = '0;
    lane_number        = '0;
    offered_word       = '0;
    shadow_cfg         = '0;
    fails              = 0;
    hold_request       = 1'b0;
    none               = '0;

    // Directed table. Known answers only where they are obvious; the rest
    // goes through the predictor.
    // Reset descriptor: zero stride, zero record count.
    c = mk_cfg(0, 0, 0, 0, 0);
    directed_rows.push_back(mk_row(c, 32'hFFFF_FFFF, 32'h10, 32'h20, 6'd63, 1, 32'h30, 0, 1));
    directed_rows.push_back(mk_row(c, 32'h0, 32'hFFFF_FFFF, 32'h1, 6'd0, 1, 32'h0, 0, 1));
    directed_rows.push_back(mk_row(c, 32'h0, 32'h0, 32'h0, 6'd0, 1, 32'h0, 0, 1));
    // Largest stride, not a dword multiple; full record count.
    c = mk_cfg(STRIDE_MAX, 0, 0, 0, COUNT_MAX);
    directed_rows.push_back(mk_row(c, 32'h1, 32'h0, 32'h0, 6'd0, 1, 32'h3FFF, 0, 0));
    directed_rows.push_back(mk_row(c, 32'hFFFF_FFFF, 32'h0, 32'h0, 6'd0, 1,
                                   32'hFFFF_C001, 0, 0));
    directed_rows.push_back(mk_row(c, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd21,
                                   0, 0, 0, 0));
    // Dword-multiple stride with the lane added; the lane add wraps the index.
    c = mk_cfg(STRIDE_MAX & ~14'd3, 1, 0, 0, 1);
    directed_rows.push_back(mk_row(c, 32'h0, 32'h0, 32'h0, 6'd63, 1, 32'h000F_BF04, 1, 0));
    directed_rows.push_back(mk_row(c, 32'hFFFF_FFFF, 32'h100, 32'h0, 6'd1, 1, 32'h100, 1, 0));
    directed_rows.push_back(mk_row(c, 32'hFFFF_FFC1, 32'h7, 32'h9, 6'd62, 0, 0, 0, 0));
    // Swizzle requested with zero stride: falls back to the plain equation.
    c = mk_cfg(0, 0, 1, 3, 5);
    directed_rows.push_back(mk_row(c, 32'hDEAD_BEEF, 32'h1003, 32'h10, 6'd0, 1,
                                   32'h1013, 0, 0));
    directed_rows.push_back(mk_row(c, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63,
                                   0, 0, 0, 0));
    // Swizzle, one descriptor for each element stride.
    c = mk_cfg(4, 0, 1, 0, 7);
    directed_rows.push_back(mk_row(c, 32'h9, 32'h6, 32'h0, 6'd0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(c, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 6'd0, 0, 0, 0, 0));
    c = mk_cfg(100, 1, 1, 1, 32'h8000_0000);
    directed_rows.push_back(mk_row(c, 32'h1F, 32'h13, 32'h4, 6'd33, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(c, 32'hFFFF_FFF0, 32'h8000_0003, 32'h7FFF_FFFF, 6'd63,
                                   0, 0, 0, 0));
    c = mk_cfg(STRIDE_MAX, 0, 1, 2, COUNT_MAX);
    directed_rows.push_back(mk_row(c, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0,
                                   0, 0, 0, 0));
    directed_rows.push_back(mk_row(c, 32'h0000_0020, 32'h0000_0001, 32'h0, 6'd0, 0, 0, 0, 0));
    c = mk_cfg(STRIDE_MAX & ~14'd3, 1, 1, 3, 0);
    directed_rows.push_back(mk_row(c, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63,
                                   0, 0, 0, 0));
    directed_rows.push_back(mk_row(c, 32'h0000_003F, 32'h0000_0002, 32'h1, 6'd1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(c, 32'h0, 32'h0, 32'h0, 6'd0, 0, 0, 0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the table; reload the descriptor only with the pipeline empty.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.cfg != shadow_cfg) begin
        drain_words();
        load_descriptor(row.cfg);
      end
      send_word(row.idx, row.off, row.soff, row.lane, pick_gap(0), row.typed, row.want);
    end

    // Random phases: extremes first, then random descriptors.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_words();
      case (p)
        0:       c = mk_cfg(0, 1'($urandom_range(0, 1)), 1, EslW'($urandom_range(0, 3)), 0);
        1:       c = mk_cfg(STRIDE_MAX, 1, 1, 3, COUNT_MAX);
        2:       c = mk_cfg(STRIDE_MAX & ~14'd3, 0, 1, 0, 1);
        default: c = random_cfg();
      endcase
      load_descriptor(c);
      no_idle = (p == 5);
      for (int w = 0; w < PHASE_WORDS; w++) begin
        // Pause the sender until everything has come back.
        if (p == 3 && w == 60) begin
          drain_words();
        end
        // Ask the result side for a long hold-off while words keep coming.
        if (p == 4 && w == 20) begin
          hold_request = 1'b1;
        end
        send_word(pick_field(), pick_field(), pick_field(), LaneW'($urandom_range(0, 63)),
                  (p == 4) ? 0 : pick_gap(no_idle), 0, none);
      end
    end

    drain_words();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
